// ===== hdl/svmt_pkg.sv =====
package svmt_pkg;

  // field widths
  localparam int TypeW   = 3;
  localparam int ChromW  = 10;
  localparam int PosW    = 31;
  localparam int LenW    = 30;
  localparam int FracW   = 16;
  localparam int FracSh  = 12;
  localparam int OvlW    = 32;
  localparam int ProdW   = FracW + LenW;
  localparam int DistW   = 31;

  // record type codes
  localparam logic [TypeW-1:0] SV_DEL = 3'd0;
  localparam logic [TypeW-1:0] SV_DUP = 3'd1;
  localparam logic [TypeW-1:0] SV_INV = 3'd2;
  localparam logic [TypeW-1:0] SV_TRA = 3'd3;

  // fail reason codes
  localparam logic [2:0] FAIL_NONE  = 3'd0;
  localparam logic [2:0] FAIL_TYPE  = 3'd1;
  localparam logic [2:0] FAIL_CHROM = 3'd2;
  localparam logic [2:0] FAIL_OVL   = 3'd3;
  localparam logic [2:0] FAIL_SIZE  = 3'd4;
  localparam logic [2:0] FAIL_DIST  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_MIN_OVERLAP = 2'd0;
  localparam logic [1:0] REG_MAX_SIZE    = 2'd1;
  localparam logic [1:0] REG_MAX_DIST    = 2'd2;

  typedef struct packed {
    logic [FracW-1:0] min_ovl;
    logic [FracW-1:0] max_size;
    logic [DistW-1:0] dist_limit;
  } svmt_cfg_t;

  typedef struct packed {
    logic [TypeW-1:0]  kind;
    logic [ChromW-1:0] c1;
    logic [ChromW-1:0] c2;
    logic [PosW-1:0]   p1;
    logic [PosW-1:0]   p2;
    logic [LenW-1:0]   len;
  } sv_rec_t;

  // after normalization
  typedef struct packed {
    sv_rec_t a;
    sv_rec_t b;
    logic    kind_eq;
    logic    chrom_eq;
  } s1_t;

  // after interval geometry
  typedef struct packed {
    logic [TypeW-1:0] kind;
    logic             kind_eq;
    logic             chrom_eq;
    logic [OvlW-1:0]  ov;
    logic [LenW-1:0]  len_a;
    logic [LenW-1:0]  len_b;
    logic [LenW-1:0]  dlen;
    logic [PosW-1:0]  dp1;
    logic [PosW-1:0]  dp2;
    logic [DistW-1:0] lim;
  } s2_t;

  // after products
  typedef struct packed {
    logic [TypeW-1:0] kind;
    logic             kind_eq;
    logic             chrom_eq;
    logic [OvlW-1:0]  ov;
    logic [LenW-1:0]  dlen;
    logic [ProdW-1:0] po_a;
    logic [ProdW-1:0] po_b;
    logic [ProdW-1:0] ps_a;
    logic [ProdW-1:0] ps_b;
    logic             dist_ok;
  } s3_t;

endpackage

// ===== hdl/svmt_norm.sv =====
module svmt_norm (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  svmt_pkg::sv_rec_t rec_a,
  input  svmt_pkg::sv_rec_t rec_b,
  output logic             out_valid,
  input  logic             out_ready,
  output svmt_pkg::s1_t    out_data
);
  import svmt_pkg::*;

  sv_rec_t na;
  sv_rec_t nb;
  s1_t     data_next;

  // swap chromosome pair and breakpoints of a reversed translocation
  function automatic sv_rec_t norm_rec(input sv_rec_t r);
    sv_rec_t o;
    o = r;
    if (r.kind == SV_TRA && r.c1 > r.c2) begin
      o.c1 = r.c2;
      o.c2 = r.c1;
      o.p1 = r.p2;
      o.p2 = r.p1;
    end
    return o;
  endfunction

  always_comb begin
    na = norm_rec(rec_a);
    nb = norm_rec(rec_b);
    data_next.a        = na;
    data_next.b        = nb;
    data_next.kind_eq  = (na.kind == nb.kind);
    data_next.chrom_eq = (na.c1 == nb.c1) && (na.c2 == nb.c2);
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== hdl/svmt_geom.sv =====
module svmt_geom (
  input  logic                clk,
  input  logic                rst,
  input  svmt_pkg::svmt_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  svmt_pkg::s1_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output svmt_pkg::s2_t       out_data
);
  import svmt_pkg::*;

  logic [PosW-1:0]  ov_s;
  logic [PosW-1:0]  ov_e;
  logic [DistW-1:0] two_len;
  s2_t              data_next;

  function automatic logic [PosW-1:0] absd(input logic [PosW-1:0] x,
                                           input logic [PosW-1:0] y);
    return (x > y) ? x - y : y - x;
  endfunction

  always_comb begin
    // inclusive overlap: later start to earlier end
    ov_s = (in_data.a.p1 > in_data.b.p1) ? in_data.a.p1 : in_data.b.p1;
    ov_e = (in_data.a.p2 < in_data.b.p2) ? in_data.a.p2 : in_data.b.p2;
    two_len = {in_data.a.len, 1'b0};

    data_next.kind     = in_data.a.kind;
    data_next.kind_eq  = in_data.kind_eq;
    data_next.chrom_eq = in_data.chrom_eq;
    data_next.ov       = (ov_e < ov_s) ? '0 :
                         ({1'b0, ov_e} - {1'b0, ov_s} + OvlW'(1));
    data_next.len_a    = in_data.a.len;
    data_next.len_b    = in_data.b.len;
    data_next.dlen     = (in_data.a.len > in_data.b.len) ?
                         in_data.a.len - in_data.b.len :
                         in_data.b.len - in_data.a.len;
    data_next.dp1      = absd(in_data.a.p1, in_data.b.p1);
    data_next.dp2      = absd(in_data.a.p2, in_data.b.p2);
    // distance limit clamped to twice a nonzero first length
    data_next.lim      = (in_data.a.len != '0 && two_len < cfg.dist_limit) ?
                         two_len : cfg.dist_limit;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== hdl/svmt_mult.sv =====
module svmt_mult (
  input  logic                clk,
  input  logic                rst,
  input  svmt_pkg::svmt_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  svmt_pkg::s2_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output svmt_pkg::s3_t       out_data
);
  import svmt_pkg::*;

  s3_t data_next;

  // four 16x30 products for the ratio tests, distance compare alongside
  always_comb begin
    data_next.kind     = in_data.kind;
    data_next.kind_eq  = in_data.kind_eq;
    data_next.chrom_eq = in_data.chrom_eq;
    data_next.ov       = in_data.ov;
    data_next.dlen     = in_data.dlen;
    data_next.po_a     = ProdW'(cfg.min_ovl) * ProdW'(in_data.len_a);
    data_next.po_b     = ProdW'(cfg.min_ovl) * ProdW'(in_data.len_b);
    data_next.ps_a     = ProdW'(cfg.max_size) * ProdW'(in_data.len_a);
    data_next.ps_b     = ProdW'(cfg.max_size) * ProdW'(in_data.len_b);
    data_next.dist_ok  = (in_data.dp1 < in_data.lim) && (in_data.dp2 < in_data.lim);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== hdl/svmt_decide.sv =====
module svmt_decide (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  svmt_pkg::s3_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          is_match,
  output logic [2:0]    fail_reason,
  output logic [31:0]   overlap_len
);
  import svmt_pkg::*;

  logic [ProdW-1:0] ov_lhs;
  logic [ProdW-1:0] sz_lhs;
  logic             ovl_pass;
  logic             size_pass;
  logic [2:0]       reason_next;

  always_comb begin
    ov_lhs    = ProdW'({in_data.ov, FracSh'(0)});
    sz_lhs    = ProdW'({in_data.dlen, FracSh'(0)});
    ovl_pass  = (in_data.ov != '0) && (ov_lhs >= in_data.po_a) &&
                (ov_lhs >= in_data.po_b);
    size_pass = (sz_lhs < in_data.ps_a) && (sz_lhs < in_data.ps_b);

    // first failing test in priority order
    reason_next = FAIL_NONE;
    if (!in_data.kind_eq) begin
      reason_next = FAIL_TYPE;
    end else if (!in_data.chrom_eq) begin
      reason_next = FAIL_CHROM;
    end else if (in_data.kind == SV_DEL || in_data.kind == SV_DUP ||
                 in_data.kind == SV_INV) begin
      if (!ovl_pass) begin
        reason_next = FAIL_OVL;
      end else if (!size_pass) begin
        reason_next = FAIL_SIZE;
      end else if (!in_data.dist_ok) begin
        reason_next = FAIL_DIST;
      end
    end else if (in_data.kind == SV_TRA) begin
      if (!in_data.dist_ok) begin
        reason_next = FAIL_DIST;
      end
    end else begin
      if (!size_pass) begin
        reason_next = FAIL_SIZE;
      end else if (!in_data.dist_ok) begin
        reason_next = FAIL_DIST;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      is_match    <= (reason_next == FAIL_NONE);
      fail_reason <= reason_next;
      overlap_len <= in_data.ov;
    end
  end

  // result fields agree with each other
  a_match_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_match == (fail_reason == FAIL_NONE)))
    else $error("is_match disagrees with fail_reason");

  a_reason_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fail_reason <= FAIL_DIST))
    else $error("fail_reason out of range");

  // a transaction that is held keeps its result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(fail_reason) &&
                                   $stable(overlap_len)))
    else $error("stalled result changed");

endmodule

// ===== hdl/structural_variant_match_test_core.sv =====
// Structural-variant match test. Each transaction carries two variant records
// (type, chromosome pair, two breakpoints, length); one result per transaction
// reports whether they match, the first failing test (type, chromosome,
// reciprocal overlap, size, breakpoint distance) and the inclusive overlap
// length. Translocations with a reversed chromosome pair are normalized first.
// The datapath is a four-stage pipeline (normalize, interval geometry, ratio
// products, decision) that accepts one transaction per clock, each stage
// registered in turn from input to output; throughput is bounded only by output
// backpressure. Configuration writes take effect on the next clock and are
// meant to be made while no transaction is in flight.
module structural_variant_match_test_core (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  type_a,
  input  logic [9:0]  chrom1_a,
  input  logic [9:0]  chrom2_a,
  input  logic [30:0] pos1_a,
  input  logic [30:0] pos2_a,
  input  logic [29:0] len_a,
  input  logic [2:0]  type_b,
  input  logic [9:0]  chrom1_b,
  input  logic [9:0]  chrom2_b,
  input  logic [30:0] pos1_b,
  input  logic [30:0] pos2_b,
  input  logic [29:0] len_b,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_match,
  output logic [2:0]  fail_reason,
  output logic [31:0] overlap_len
);
  import svmt_pkg::*;

  svmt_cfg_t cfg;
  sv_rec_t   rec_a;
  sv_rec_t   rec_b;
  s1_t       s1_data;
  s2_t       s2_data;
  s3_t       s3_data;
  logic      s1_valid;
  logic      s2_valid;
  logic      s3_valid;
  logic      s2_ready;
  logic      s3_ready;
  logic      s4_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_ovl    <= FracW'(2048);
      cfg.max_size   <= FracW'(2048);
      cfg.dist_limit <= DistW'(1000);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_OVERLAP: cfg.min_ovl    <= cfg_data[FracW-1:0];
        REG_MAX_SIZE:    cfg.max_size   <= cfg_data[FracW-1:0];
        REG_MAX_DIST:    cfg.dist_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    rec_a = '{kind: type_a, c1: chrom1_a, c2: chrom2_a, p1: pos1_a, p2: pos2_a,
              len: len_a};
    rec_b = '{kind: type_b, c1: chrom1_b, c2: chrom2_b, p1: pos1_b, p2: pos2_b,
              len: len_b};
  end

  svmt_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rec_a     (rec_a),
    .rec_b     (rec_b),
    .out_valid (s1_valid),
    .out_ready (s2_ready),
    .out_data  (s1_data)
  );

  svmt_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s1_valid),
    .in_ready  (s2_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s3_ready),
    .out_data  (s2_data)
  );

  svmt_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s2_valid),
    .in_ready  (s3_ready),
    .in_data   (s2_data),
    .out_valid (s3_valid),
    .out_ready (s4_ready),
    .out_data  (s3_data)
  );

  svmt_decide u_decide (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s3_valid),
    .in_ready    (s4_ready),
    .in_data     (s3_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .is_match    (is_match),
    .fail_reason (fail_reason),
    .overlap_len (overlap_len)
  );

  // an accepted transaction lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted transaction lost at first stage");

  // the stalled product stage keeps its transaction
  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !s4_ready) |=> (s3_valid && $stable(s3_data)))
    else $error("stalled product stage changed");

  // the product stage takes the transaction offered to it
  a_cfg_prod: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s3_ready && !cfg_write) |=>
      (s3_data.dlen == $past(s2_data.dlen)))
    else $error("product stage took wrong transaction");

endmodule
